// ===== rtl/lft_pkg.sv =====
// Shared types and constants of the failed-login lockout table.
package lft_pkg;

    localparam int TIME_BITS    = 48;
    localparam int COUNT_BITS   = 16;
    localparam int REMOVED_BITS = 13;
    localparam int CMD_BITS     = 2;
    localparam int IN_KEY_BITS  = 64;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DAT_BITS = 32;
    localparam int ATTEMPT_BITS = 8;
    localparam int LOCK_BITS    = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FREE_ATTEMPTS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_LOCK     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LOCK      = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FORGET        = 2'd3;

    localparam logic [ATTEMPT_BITS-1:0] FREE_ATTEMPTS_RST = 8'd5;
    localparam logic [LOCK_BITS-1:0]    BASE_LOCK_RST     = 32'd30000;
    localparam logic [LOCK_BITS-1:0]    MAX_LOCK_RST      = 32'd960000;
    localparam logic [LOCK_BITS-1:0]    FORGET_RST        = 32'd3600000;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_QUERY   = 2'd0,
        CMD_FAIL    = 2'd1,
        CMD_SUCCESS = 2'd2,
        CMD_EXPIRE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_AGE,
        ST_CHECK,
        ST_BACKOFF,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Request to the lockout length unit.
    typedef struct packed {
        logic                  start;
        logic [COUNT_BITS-1:0] over;
        logic [LOCK_BITS-1:0]  base;
        logic [LOCK_BITS-1:0]  cap;
    } bo_req_t;

    // Answer of the lockout length unit.
    typedef struct packed {
        logic                 done;
        logic [LOCK_BITS-1:0] lock;
    } bo_rsp_t;

endpackage

// ===== rtl/failed_login_lockout_table.sv =====
// Sequence: query, success and expire scan every entry, then pass PICK and DONE. A failure
// that finds or claims an entry also passes AGE, CHECK and WRITE, and BACKOFF when the key
// gets locked, where the lockout length unit works out the length (one doubling a cycle).
// Throughput: one item at a time; the table scan through the single read port sets the rate,
// so the next input beat is taken once the previous result sits in the output register.
// Reset (aresetn, synchronous, active low) restores the register defaults and then runs a
// clearing pass over every entry of the store; s_ready stays low during it.
module failed_login_lockout_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS      = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [lft_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [lft_pkg::CFG_DAT_BITS-1:0]    cfg_wdata,
    // Input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lft_pkg::CMD_BITS-1:0]        s_command,
    input  logic [lft_pkg::IN_KEY_BITS-1:0]     s_client_key,
    input  logic [lft_pkg::TIME_BITS-1:0]       s_now_ms,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lft_pkg::TIME_BITS-1:0]       m_locked_ms,
    output logic [lft_pkg::COUNT_BITS-1:0]      m_fail_count,
    output logic                                m_table_full,
    output logic [lft_pkg::REMOVED_BITS-1:0]    m_removed_count
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int TB = lft_pkg::TIME_BITS;
    localparam int NB = lft_pkg::COUNT_BITS;
    localparam logic [CW-1:0] CTR_END  = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0] CTR_LAST = CW'(TABLE_ENTRIES - 1);

    // One table entry as it lies in the store. The valid bit lives in the store
    // itself, which is why reset has to sweep it clear.
    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [NB-1:0]       fails;
        logic [TB-1:0]       last;
        logic [TB-1:0]       lock_end;
    } entry_t;

    localparam int EW = $bits(entry_t);

    // Configuration registers
    logic [lft_pkg::ATTEMPT_BITS-1:0] free_attempts_reg;
    logic [lft_pkg::LOCK_BITS-1:0]    base_lock_reg;
    logic [lft_pkg::LOCK_BITS-1:0]    max_lock_reg;
    logic [lft_pkg::LOCK_BITS-1:0]    forget_reg;

    // Sequencer state
    lft_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   ctr_reg, ctr_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   addr_q_reg, addr_q_next;
    lft_pkg::cmd_t   cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [TB-1:0]   now_reg, now_next;
    logic            found_reg, found_next;
    logic [AW-1:0]   slot_reg, slot_next;
    logic            free_found_reg, free_found_next;
    logic [AW-1:0]   free_slot_reg, free_slot_next;
    logic [NB-1:0]   fails_reg, fails_next;
    logic [TB-1:0]   last_reg, last_next;
    logic [TB-1:0]   lu_reg, lu_next;
    logic            full_reg, full_next;
    logic [CW-1:0]   removed_reg, removed_next;

    // Output register
    logic                 m_valid_reg, m_valid_next;
    logic [TB-1:0]        m_locked_reg, m_locked_next;
    logic [NB-1:0]        m_count_reg, m_count_next;
    logic                 m_full_reg, m_full_next;
    logic [lft_pkg::REMOVED_BITS-1:0] m_removed_reg, m_removed_next;

    // Store ports
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    entry_t          mem_wentry;
    logic [AW-1:0]   mem_raddr;
    logic [EW-1:0]   mem_rdata;
    entry_t          rd_entry;

    lft_pkg::bo_req_t bo_req;
    lft_pkg::bo_rsp_t bo_rsp;

    lft_mem #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (EW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wentry),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lft_backoff u_backoff (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bo_req),
        .rsp     (bo_rsp)
    );

    assign rd_entry = entry_t'(mem_rdata);

    // Configuration writes are taken whenever the enable is high.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_attempts_reg <= lft_pkg::FREE_ATTEMPTS_RST;
            base_lock_reg     <= lft_pkg::BASE_LOCK_RST;
            max_lock_reg      <= lft_pkg::MAX_LOCK_RST;
            forget_reg        <= lft_pkg::FORGET_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                lft_pkg::CFG_FREE_ATTEMPTS: begin
                    free_attempts_reg <= cfg_wdata[lft_pkg::ATTEMPT_BITS-1:0];
                end
                lft_pkg::CFG_BASE_LOCK: begin
                    base_lock_reg <= cfg_wdata;
                end
                lft_pkg::CFG_MAX_LOCK: begin
                    max_lock_reg <= cfg_wdata;
                end
                lft_pkg::CFG_FORGET: begin
                    forget_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // State register and the registers that the sequencer steers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= lft_pkg::ST_CLEAR;
            ctr_reg        <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            full_reg       <= 1'b0;
            removed_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ctr_reg        <= ctr_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            full_reg       <= full_next;
            removed_reg    <= removed_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_q_reg    <= addr_q_next;
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        now_reg       <= now_next;
        slot_reg      <= slot_next;
        free_slot_reg <= free_slot_next;
        fails_reg     <= fails_next;
        last_reg      <= last_next;
        lu_reg        <= lu_next;
        m_locked_reg  <= m_locked_next;
        m_count_reg   <= m_count_next;
        m_full_reg    <= m_full_next;
        m_removed_reg <= m_removed_next;
    end

    // Next state, store accesses and result assembly.
    always_comb begin
        logic          hit;
        logic          drop;
        logic [TB:0]   quiet_sum;
        logic [TB-1:0] age;
        logic [NB-1:0] base_fails;
        logic [TB:0]   end_sum;

        state_next      = state_reg;
        ctr_next        = ctr_reg;
        pend_next       = 1'b0;
        addr_q_next     = addr_q_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        fails_next      = fails_reg;
        last_next       = last_reg;
        lu_next         = lu_reg;
        full_next       = full_reg;
        removed_next    = removed_reg;

        m_valid_next   = m_valid_reg && !m_ready;
        m_locked_next  = m_locked_reg;
        m_count_next   = m_count_reg;
        m_full_next    = m_full_reg;
        m_removed_next = m_removed_reg;

        mem_we     = 1'b0;
        mem_waddr  = addr_q_reg;
        mem_wentry = '0;
        mem_raddr  = ctr_reg[AW-1:0];

        bo_req.start = 1'b0;
        bo_req.over  = fails_reg - NB'(free_attempts_reg) - 1'b1;
        bo_req.base  = base_lock_reg;
        bo_req.cap   = max_lock_reg;

        s_ready = 1'b0;

        hit        = rd_entry.valid && (rd_entry.key == key_reg);
        quiet_sum  = {1'b0, rd_entry.last} + (TB + 1)'(forget_reg);
        drop       = (cmd_reg == lft_pkg::CMD_EXPIRE) && rd_entry.valid
                     && (quiet_sum < {1'b0, now_reg}) && (now_reg >= rd_entry.lock_end);
        age        = now_reg - last_reg;
        base_fails = (age > TB'(forget_reg)) ? '0 : fails_reg;
        end_sum    = {1'b0, now_reg} + (TB + 1)'(bo_rsp.lock);

        case (state_reg)
            lft_pkg::ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = ctr_reg[AW-1:0];
                mem_wentry = '0;
                ctr_next   = ctr_reg + 1'b1;
                if (ctr_reg == CTR_LAST) begin
                    state_next = lft_pkg::ST_IDLE;
                end
            end

            lft_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next        = lft_pkg::cmd_t'(s_command);
                    key_next        = s_client_key[KEY_BITS-1:0];
                    now_next        = s_now_ms;
                    ctr_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    full_next       = 1'b0;
                    removed_next    = '0;
                    state_next      = lft_pkg::ST_SCAN;
                end
            end

            lft_pkg::ST_SCAN: begin
                // Issue one read a cycle; the data comes back in the next cycle.
                if (ctr_reg != CTR_END) begin
                    pend_next   = 1'b1;
                    addr_q_next = ctr_reg[AW-1:0];
                    ctr_next    = ctr_reg + 1'b1;
                end else if (!pend_reg) begin
                    state_next = lft_pkg::ST_PICK;
                end

                if (pend_reg) begin
                    if (drop) begin
                        mem_we       = 1'b1;
                        mem_wentry   = rd_entry;
                        mem_wentry.valid = 1'b0;
                        removed_next = removed_reg + 1'b1;
                    end
                    if (cmd_reg == lft_pkg::CMD_SUCCESS) begin
                        if (hit) begin
                            mem_we           = 1'b1;
                            mem_wentry       = rd_entry;
                            mem_wentry.valid = 1'b0;
                        end
                    end else if (hit && !drop && !found_reg) begin
                        found_next = 1'b1;
                        slot_next  = addr_q_reg;
                        fails_next = rd_entry.fails;
                        last_next  = rd_entry.last;
                        lu_next    = rd_entry.lock_end;
                    end
                    if (!rd_entry.valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_slot_next  = addr_q_reg;
                    end
                end
            end

            lft_pkg::ST_PICK: begin
                if (cmd_reg == lft_pkg::CMD_FAIL) begin
                    if (found_reg) begin
                        state_next = lft_pkg::ST_AGE;
                    end else if (free_found_reg) begin
                        // A new key starts empty with its last failure at now.
                        found_next = 1'b1;
                        slot_next  = free_slot_reg;
                        fails_next = '0;
                        last_next  = now_reg;
                        lu_next    = '0;
                        state_next = lft_pkg::ST_AGE;
                    end else begin
                        full_next  = 1'b1;
                        state_next = lft_pkg::ST_DONE;
                    end
                end else begin
                    state_next = lft_pkg::ST_DONE;
                end
            end

            lft_pkg::ST_AGE: begin
                // A long quiet gap, or time running backwards, restarts the count.
                fails_next = (&base_fails) ? base_fails : base_fails + 1'b1;
                last_next  = now_reg;
                state_next = lft_pkg::ST_CHECK;
            end

            lft_pkg::ST_CHECK: begin
                if (fails_reg > NB'(free_attempts_reg)) begin
                    bo_req.start = 1'b1;
                    state_next   = lft_pkg::ST_BACKOFF;
                end else begin
                    state_next = lft_pkg::ST_WRITE;
                end
            end

            lft_pkg::ST_BACKOFF: begin
                if (bo_rsp.done) begin
                    lu_next    = end_sum[TB] ? '1 : end_sum[TB-1:0];
                    state_next = lft_pkg::ST_WRITE;
                end
            end

            lft_pkg::ST_WRITE: begin
                mem_we              = 1'b1;
                mem_waddr           = slot_reg;
                mem_wentry.valid    = 1'b1;
                mem_wentry.key      = key_reg;
                mem_wentry.fails    = fails_reg;
                mem_wentry.last     = last_reg;
                mem_wentry.lock_end = lu_reg;
                state_next          = lft_pkg::ST_DONE;
            end

            lft_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_locked_next  = (found_reg && (now_reg < lu_reg)) ? lu_reg - now_reg : '0;
                    m_count_next   = found_reg ? fails_reg : '0;
                    m_full_next    = full_reg;
                    m_removed_next = lft_pkg::REMOVED_BITS'(removed_reg);
                    state_next     = lft_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = lft_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_locked_ms     = m_locked_reg;
    assign m_fail_count    = m_count_reg;
    assign m_table_full    = m_full_reg;
    assign m_removed_count = m_removed_reg;

`ifndef SYNTHESIS
    // Only a success or a sweep may drop entries during the scan.
    a_scan_write_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lft_pkg::ST_SCAN && mem_we)
        |-> (cmd_reg == lft_pkg::CMD_SUCCESS || cmd_reg == lft_pkg::CMD_EXPIRE))
        else $error("store written during scan for a command that keeps entries");

    // A dropped count only ever builds up during an expire sweep.
    a_removed_expire: assert property (@(posedge aclk) disable iff (!aresetn)
        (removed_reg != '0) |-> (cmd_reg == lft_pkg::CMD_EXPIRE))
        else $error("entries counted as removed outside a sweep");

    // A full table means the failure found no entry to report.
    a_full_no_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> !found_reg)
        else $error("table full flagged while an entry is held");

    // The lockout length unit finishes only while the sequencer waits for it.
    a_backoff_done: assert property (@(posedge aclk) disable iff (!aresetn)
        bo_rsp.done |-> (state_reg == lft_pkg::ST_BACKOFF))
        else $error("lockout length finished outside its wait state");

    // Loading the output register returns the sequencer to idle.
    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lft_pkg::ST_DONE && (!m_valid_reg || m_ready))
        |=> (state_reg == lft_pkg::ST_IDLE && m_valid_reg))
        else $error("result loaded without returning to idle");
`endif

endmodule

// ===== rtl/lft_mem.sv =====
// Entry store of the lockout table: one write port, one registered read port.
module lft_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 177
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lft_backoff.sv =====
// Lockout length unit: doubles the base length once a cycle, as often as asked, up to the cap.
module lft_backoff (
    input  logic              aclk,
    input  logic              aresetn,
    input  lft_pkg::bo_req_t  req,
    output lft_pkg::bo_rsp_t  rsp
);

    logic                           busy_reg;
    logic [lft_pkg::LOCK_BITS:0]    lock_reg;
    logic [lft_pkg::COUNT_BITS-1:0] over_reg;
    logic                           step;

    // A zero length stays zero, so doubling stops there as well.
    assign step = (over_reg != '0) && (lock_reg < {1'b0, req.cap}) && (lock_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && !step) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            lock_reg <= {1'b0, req.base};
            over_reg <= req.over;
        end else if (busy_reg && step) begin
            lock_reg <= {lock_reg[lft_pkg::LOCK_BITS-1:0], 1'b0};
            over_reg <= over_reg - 1'b1;
        end
    end

    assign rsp.done = busy_reg && !step;
    assign rsp.lock = (lock_reg > {1'b0, req.cap}) ? req.cap
                                                   : lock_reg[lft_pkg::LOCK_BITS-1:0];

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the failed-login lockout table.
module tb_top;

    // The block under test is built with its default table of 64 entries and full-width keys.
    localparam int TABLE_SIZE = 64;
    localparam int KEY_WIDTH  = 64;

    // The slowest correct run is roughly 500 command beats, each a full table scan plus a lockout
    // length search, plus sender gaps, receiver stalls, one long hold-off and the clearing pass
    // after reset. The limit below leaves a wide margin on top of that.
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [lft_pkg::TIME_BITS-1:0] TIME_MAX = '1;

    // One result beat as the block should present it.
    typedef struct packed {
        logic [lft_pkg::TIME_BITS-1:0]    locked_ms;
        logic [lft_pkg::COUNT_BITS-1:0]   fail_count;
        logic                             table_full;
        logic [lft_pkg::REMOVED_BITS-1:0] removed_count;
    } lockout_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_we;
    logic [lft_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [lft_pkg::CFG_DAT_BITS-1:0] cfg_wdata;
    logic                             s_valid;
    logic                             s_ready;
    logic [lft_pkg::CMD_BITS-1:0]     s_command;
    logic [lft_pkg::IN_KEY_BITS-1:0]  s_client_key;
    logic [lft_pkg::TIME_BITS-1:0]    s_now_ms;
    logic                             m_valid;
    logic                             m_ready;
    logic [lft_pkg::TIME_BITS-1:0]    m_locked_ms;
    logic [lft_pkg::COUNT_BITS-1:0]   m_fail_count;
    logic                             m_table_full;
    logic [lft_pkg::REMOVED_BITS-1:0] m_removed_count;

    failed_login_lockout_table #(
        .TABLE_ENTRIES (TABLE_SIZE),
        .KEY_BITS      (KEY_WIDTH)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_client_key    (s_client_key),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_locked_ms     (m_locked_ms),
        .m_fail_count    (m_fail_count),
        .m_table_full    (m_table_full),
        .m_removed_count (m_removed_count)
    );

    // Policy registers as the testbench believes them to be.
    logic [lft_pkg::ATTEMPT_BITS-1:0] pol_free;
    logic [lft_pkg::LOCK_BITS-1:0]    pol_base;
    logic [lft_pkg::LOCK_BITS-1:0]    pol_cap;
    logic [lft_pkg::LOCK_BITS-1:0]    pol_forget;

    // Shadow copy of the entry store, kept in step with every accepted command beat.
    bit                              row_used  [TABLE_SIZE];
    logic [lft_pkg::IN_KEY_BITS-1:0] row_key   [TABLE_SIZE];
    logic [lft_pkg::COUNT_BITS-1:0]  row_fails [TABLE_SIZE];
    logic [lft_pkg::TIME_BITS-1:0]   row_last  [TABLE_SIZE];
    logic [lft_pkg::TIME_BITS-1:0]   row_until [TABLE_SIZE];

    // Lockout answers still owed by the block, oldest first.
    lockout_t expected_lockouts[$];

    int mismatches;
    int beats_sent;
    int results_checked;
    int full_seen;
    int swept_total;
    int cycle_count;

    // Idling knobs, in percent of cycles, and the long output hold-off.
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_off;

    // Wall clock used by the random traffic, and the keys that traffic keeps returning to.
    logic [lft_pkg::TIME_BITS-1:0]   clock_ms;
    logic [lft_pkg::IN_KEY_BITS-1:0] key_pool [8];
    int                              pool_size;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------------------
    // Lockout predictor
    // ------------------------------------------------------------------------------------

    function automatic int row_of(input logic [lft_pkg::IN_KEY_BITS-1:0] key);
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (row_used[i] && row_key[i] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic int free_row();
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (!row_used[i])
                return i;
        end
        return -1;
    endfunction

    // Lockout length for a count beyond the free attempts: the base doubles once per
    // failure after the first locking one, stopping as soon as the cap is reached.
    function automatic logic [63:0] backoff_ms(input logic [lft_pkg::COUNT_BITS-1:0] fails);
        logic [31:0] extra;
        logic [63:0] lock;
        extra = 32'(fails) - 32'(pol_free) - 32'd1;
        lock  = 64'(pol_base);
        for (int unsigned i = 0; i < extra && lock < 64'(pol_cap); i++)
            lock = lock * 2;
        if (lock > 64'(pol_cap))
            lock = 64'(pol_cap);
        return lock;
    endfunction

    // Applies one command to the shadow store and returns the beat the block should answer.
    function automatic lockout_t predict_lockout(input lft_pkg::cmd_t cmd,
                                                 input logic [lft_pkg::IN_KEY_BITS-1:0] key,
                                                 input logic [lft_pkg::TIME_BITS-1:0] now);
        lockout_t                      res;
        int                            slot;
        logic [lft_pkg::TIME_BITS-1:0] quiet;
        logic [63:0]                   lock_end;
        res = '0;
        case (cmd)
            lft_pkg::CMD_FAIL: begin
                slot = row_of(key);
                if (slot < 0) begin
                    slot = free_row();
                    if (slot >= 0) begin
                        row_used[slot]  = 1'b1;
                        row_key[slot]   = key;
                        row_fails[slot] = '0;
                        row_last[slot]  = now;
                        row_until[slot] = '0;
                    end
                end
                if (slot < 0) begin
                    res.table_full = 1'b1;
                end else begin
                    // The quiet time wraps at the width of the clock, so a clock that runs
                    // backwards looks like a very long silence and restarts the count.
                    quiet = now - row_last[slot];
                    if (64'(quiet) > 64'(pol_forget))
                        row_fails[slot] = '0;
                    if (row_fails[slot] != '1)
                        row_fails[slot] = row_fails[slot] + 1'b1;
                    row_last[slot] = now;
                    if (32'(row_fails[slot]) > 32'(pol_free)) begin
                        lock_end = 64'(now) + backoff_ms(row_fails[slot]);
                        row_until[slot] = (lock_end > 64'(TIME_MAX))
                                          ? TIME_MAX : lock_end[lft_pkg::TIME_BITS-1:0];
                    end
                end
            end
            lft_pkg::CMD_SUCCESS: begin
                slot = row_of(key);
                if (slot >= 0)
                    row_used[slot] = 1'b0;
            end
            lft_pkg::CMD_EXPIRE: begin
                for (int i = 0; i < TABLE_SIZE; i++) begin
                    if (row_used[i] && 64'(row_last[i]) + 64'(pol_forget) < 64'(now)
                        && now >= row_until[i]) begin
                        row_used[i] = 1'b0;
                        res.removed_count = res.removed_count + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        // Every command answers with the state of its own key afterwards.
        slot = row_of(key);
        if (slot >= 0) begin
            res.fail_count = row_fails[slot];
            if (now < row_until[slot])
                res.locked_ms = row_until[slot] - now;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------------------------

    // Offers one command beat, with a random gap in front of it, and records what the block
    // owes once the beat has been taken.
    task automatic send_item(input lft_pkg::cmd_t cmd,
                             input logic [lft_pkg::IN_KEY_BITS-1:0] key,
                             input logic [lft_pkg::TIME_BITS-1:0] now);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_client_key <= key;
        s_now_ms     <= now;
        do @(posedge aclk); while (!s_ready);
        expected_lockouts.push_back(predict_lockout(cmd, key, now));
        beats_sent++;
    endtask

    // Stops offering and waits until every outstanding answer has been taken. The block
    // answers each command exactly once, so an empty queue means it is idle again.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_lockouts.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [lft_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            lft_pkg::CFG_FREE_ATTEMPTS: pol_free   = value[lft_pkg::ATTEMPT_BITS-1:0];
            lft_pkg::CFG_BASE_LOCK:     pol_base   = value;
            lft_pkg::CFG_MAX_LOCK:      pol_cap    = value;
            lft_pkg::CFG_FORGET:        pol_forget = value;
            default: ;
        endcase
    endtask

    task automatic set_policy(input logic [31:0] free, input logic [31:0] base,
                              input logic [31:0] cap, input logic [31:0] forget);
        wait_idle();
        write_reg(lft_pkg::CFG_FREE_ATTEMPTS, free);
        write_reg(lft_pkg::CFG_BASE_LOCK, base);
        write_reg(lft_pkg::CFG_MAX_LOCK, cap);
        write_reg(lft_pkg::CFG_FORGET, forget);
    endtask

    // One random command. Most beats revisit a small pool of keys so that counts climb and
    // locks engage; the clock mostly moves forward by steps scaled to the current policy,
    // with some steps right on the forget boundary, some backwards and some to the very top
    // of the clock range. A few beats are pure noise.
    task automatic random_item();
        int                              pick;
        int                              move;
        logic [lft_pkg::IN_KEY_BITS-1:0] key;
        logic [31:0]                     scale;
        logic [63:0]                     step;
        lft_pkg::cmd_t                   cmd;
        pick = $urandom_range(0, 99);
        move = $urandom_range(0, 99);
        key  = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_size - 1)]
                                            : {$urandom, $urandom};
        scale = (pol_base > 32'h3FFF_FFFF) ? 32'hFFFF_FFFF : pol_base * 4;
        step  = '0;
        if (move < 45)
            step = 64'($urandom_range(0, scale));
        else if (move < 65)
            step = 64'(pol_forget) - 64'd1 + 64'($urandom_range(0, 2));
        else if (move < 80)
            step = 64'($urandom_range(0, pol_forget));
        else if (move < 94 && move >= 88)
            clock_ms = clock_ms - 48'($urandom_range(0, 1000));
        else if (move >= 94)
            clock_ms = TIME_MAX - 48'($urandom_range(0, pol_base));
        clock_ms = clock_ms + step[lft_pkg::TIME_BITS-1:0];

        if (pick < 45)
            cmd = lft_pkg::CMD_FAIL;
        else if (pick < 68)
            cmd = lft_pkg::CMD_QUERY;
        else if (pick < 80)
            cmd = lft_pkg::CMD_SUCCESS;
        else
            cmd = lft_pkg::CMD_EXPIRE;

        if (pick < 95)
            send_item(cmd, key, clock_ms);
        else
            send_item(lft_pkg::cmd_t'($urandom_range(0, 3)), {$urandom, $urandom},
                      {16'($urandom), 32'($urandom)});
    endtask

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Runs at the reset policy: five free attempts, 30 s base, 960 s cap, one hour forget.
    task automatic test_directed_basics();
        logic [lft_pkg::IN_KEY_BITS-1:0] user_a;
        logic [lft_pkg::IN_KEY_BITS-1:0] user_b;
        logic [lft_pkg::IN_KEY_BITS-1:0] user_c;
        user_a = 64'h0123_4567_89AB_CDEF;
        user_b = '1;
        user_c = 64'h8000_0000_0000_0000;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Commands on an empty store answer with zeros.
        send_item(lft_pkg::CMD_QUERY, '0, '0);
        send_item(lft_pkg::CMD_SUCCESS, user_b, '0);
        send_item(lft_pkg::CMD_EXPIRE, user_b, TIME_MAX);
        // Five free failures, then the first lock and its first doubling.
        for (int i = 0; i < 7; i++)
            send_item(lft_pkg::CMD_FAIL, user_a, 48'd1000 + 48'(10 * i));
        send_item(lft_pkg::CMD_QUERY, user_a, 48'd1100);
        // Exactly the forget time after the last failure still counts as recent.
        send_item(lft_pkg::CMD_FAIL, user_a, 48'd1060 + 48'(lft_pkg::FORGET_RST));
        // A clock that steps backwards restarts the count but leaves the old lock in place.
        send_item(lft_pkg::CMD_FAIL, user_a, 48'd500);
        send_item(lft_pkg::CMD_QUERY, user_a, 48'd600);
        send_item(lft_pkg::CMD_FAIL, user_b, TIME_MAX - 48'd10);
        send_item(lft_pkg::CMD_SUCCESS, user_a, 48'd700);
        send_item(lft_pkg::CMD_QUERY, user_a, 48'd700);
        send_item(lft_pkg::CMD_QUERY, user_b, TIME_MAX);
        // The sweep drops an entry only once it is strictly older than the forget time.
        send_item(lft_pkg::CMD_FAIL, user_c, 48'd2000);
        send_item(lft_pkg::CMD_EXPIRE, user_c, 48'd2000 + 48'(lft_pkg::FORGET_RST));
        send_item(lft_pkg::CMD_EXPIRE, user_c, 48'd2001 + 48'(lft_pkg::FORGET_RST));
        send_item(lft_pkg::CMD_EXPIRE, user_b, TIME_MAX);
    endtask

    // Extreme register values and the top of the clock range.
    task automatic test_range_edges();
        logic [lft_pkg::IN_KEY_BITS-1:0] edge_key;
        edge_key = 64'h8000_0000_0000_0001;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Only the low byte of the write reaches the free-attempt register, so this is zero.
        set_policy(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // The lock end runs past the top of the clock and is held there.
        send_item(lft_pkg::CMD_FAIL, edge_key, TIME_MAX - 48'd5);
        send_item(lft_pkg::CMD_QUERY, edge_key, TIME_MAX);
        // The clock wraps to a small value: the quiet time wraps too and stays short.
        send_item(lft_pkg::CMD_FAIL, edge_key, 48'd10);
        send_item(lft_pkg::CMD_FAIL, '0, '0);
        send_item(lft_pkg::CMD_FAIL, '0, '0);
        send_item(lft_pkg::CMD_EXPIRE, '0, '0);
        send_item(lft_pkg::CMD_EXPIRE, edge_key, TIME_MAX);
        // Most attempts allowed and a forget time of one millisecond: a gap of exactly one
        // millisecond keeps the count, a gap of two restarts it.
        set_policy(32'd255, 32'd1, 32'd1, 32'd1);
        send_item(lft_pkg::CMD_FAIL, edge_key, 48'd100);
        send_item(lft_pkg::CMD_FAIL, edge_key, 48'd101);
        send_item(lft_pkg::CMD_FAIL, edge_key, 48'd103);
    endtask

    // Fills every entry, overflows the store, reuses a freed entry and sweeps the lot.
    task automatic test_table_capacity();
        logic [lft_pkg::IN_KEY_BITS-1:0] fill_keys [TABLE_SIZE];
        logic [lft_pkg::IN_KEY_BITS-1:0] leftovers [$];
        logic [lft_pkg::IN_KEY_BITS-1:0] late_key;
        set_policy(32'd3, 32'd10, 32'd1000, 32'd100000);
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        clock_ms = 48'd5_000_000;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (row_used[i])
                leftovers.push_back(row_key[i]);
        end
        while (leftovers.size() != 0)
            send_item(lft_pkg::CMD_SUCCESS, leftovers.pop_front(), clock_ms);
        for (int i = 0; i < TABLE_SIZE; i++) begin
            fill_keys[i] = {$urandom, 32'(i)};
            send_item(lft_pkg::CMD_FAIL, fill_keys[i], clock_ms);
        end
        late_key = {$urandom, 32'hFFFF_FFFF};
        send_item(lft_pkg::CMD_FAIL, late_key, clock_ms);
        send_item(lft_pkg::CMD_FAIL, fill_keys[5], clock_ms + 48'd1);
        send_item(lft_pkg::CMD_SUCCESS, fill_keys[10], clock_ms + 48'd2);
        send_item(lft_pkg::CMD_FAIL, late_key, clock_ms + 48'd3);
        send_item(lft_pkg::CMD_QUERY, late_key, clock_ms + 48'd4);
        send_item(lft_pkg::CMD_EXPIRE, late_key, clock_ms + 48'd200000);
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int beats, input int keys,
                                       input logic [31:0] free, input logic [31:0] base,
                                       input logic [31:0] cap, input logic [31:0] forget);
        set_policy(free, base, cap, forget);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        pool_size      = keys;
        for (int i = 0; i < keys; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (beats) random_item();
    endtask

    // The receiver refuses results for a long stretch while commands keep coming, so the
    // result register fills and the block has to hold off its input.
    task automatic test_input_backpressure();
        set_policy(32'd255, 32'd30000, 32'd1, 32'hFFFF_FFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pool_size      = 4;
        for (int i = 0; i < 4; i++)
            key_pool[i] = {$urandom, $urandom};
        fork
            begin
                hold_off <= 1'b1;
                repeat (400) @(posedge aclk);
                hold_off <= 1'b0;
            end
        join_none
        repeat (40) random_item();
    endtask

    // ------------------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------------------

    always @(posedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
                 field, results_checked, got, want);
        mismatches++;
    endtask

    // Every result beat is held against the oldest outstanding answer.
    always @(posedge aclk) begin : check_results
        lockout_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_lockouts.size() == 0) begin
                report_mismatch("unrequested result beat", 64'(m_locked_ms), 64'd0);
            end else begin
                want = expected_lockouts.pop_front();
                if (m_locked_ms !== want.locked_ms)
                    report_mismatch("locked_ms", 64'(m_locked_ms), 64'(want.locked_ms));
                if (m_fail_count !== want.fail_count)
                    report_mismatch("fail_count", 64'(m_fail_count), 64'(want.fail_count));
                if (m_table_full !== want.table_full)
                    report_mismatch("table_full", 64'(m_table_full), 64'(want.table_full));
                if (m_removed_count !== want.removed_count)
                    report_mismatch("removed_count", 64'(m_removed_count),
                                    64'(want.removed_count));
                results_checked++;
                if (want.table_full)
                    full_seen++;
                swept_total += int'(want.removed_count);
            end
        end
    end

    // A run that never drains ends here.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[failed_login_lockout_table] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------------------

    initial begin : stimulus
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = lft_pkg::CFG_FREE_ATTEMPTS;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_command      = lft_pkg::CMD_QUERY;
        s_client_key   = '0;
        s_now_ms       = '0;
        hold_off       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        beats_sent     = 0;
        results_checked = 0;
        full_seen      = 0;
        swept_total    = 0;
        clock_ms       = '0;
        pool_size      = 1;
        pol_free       = lft_pkg::FREE_ATTEMPTS_RST;
        pol_base       = lft_pkg::BASE_LOCK_RST;
        pol_cap        = lft_pkg::MAX_LOCK_RST;
        pol_forget     = lft_pkg::FORGET_RST;
        for (int i = 0; i < TABLE_SIZE; i++)
            row_used[i] = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // The first beat waits on s_ready, which also covers the clearing pass after reset.
        test_directed_basics();
        test_range_edges();
        test_table_capacity();
        test_random_traffic(0, 0, 90, 6, 32'd2, 32'd100, 32'd6400, 32'd5000);
        test_random_traffic(47, 0, 90, 2, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        test_random_traffic(0, 47, 90, 4, 32'd1, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1);
        test_random_traffic(17, 17, 90, 5, 32'd3, 32'd1000, 32'd300, 32'd20000);
        test_input_backpressure();

        // Drain, then allow one full lookup and backoff time for any stray beat to surface.
        wait_idle();
        repeat (120) @(posedge aclk);

        $display("Ran %0d command beats: reset and extreme policies, store overflow,",
                 beats_sent);
        $display("clock wrap, idle and stall mixes, a long output stall; %0d checked, %0d full,",
                 results_checked, full_seen);
        $display("%0d entries swept.", swept_total);
        if (mismatches == 0) begin
            $display("[failed_login_lockout_table] OK");
        end else begin
            $display("[failed_login_lockout_table] ERROR");
        end
        $finish;
    end

endmodule
